>>> hdl/fcpv_pkg.sv
// fcpv_pkg: action and status codes and fixed constants of the page victim unit
// no dependencies
package fcpv_pkg;

	typedef enum logic [1:0] {
		ACT_RECORD = 2'd0,
		ACT_ACCESS = 2'd1,
		ACT_PLACE  = 2'd2,
		ACT_VICTIM = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NOT_FOUND   = 2'd1,
		ST_FULL        = 2'd2,
		ST_NO_RESIDENT = 2'd3
	} status_t;

	localparam int unsigned ADDR_W       = 32;
	localparam int unsigned PAGE_FIELD_W = 20;
	localparam int unsigned FRAME_OUT_W  = 8;
	localparam int unsigned OFFSET_W     = 5;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd12;

endpackage

>>> hdl/fcpv_in_if.sv
// fcpv_in_if: request channel of the page victim unit
// depends on fcpv_pkg
interface fcpv_in_if import fcpv_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic [ADDR_W-1:0]         address;
	logic [PAGE_FIELD_W-1:0]   page;
	logic [FRAME_OUT_W-1:0]    frame;

	modport source (output valid, action, address, page, frame, input ready);
	modport sink (input valid, action, address, page, frame, output ready);
endinterface

>>> hdl/fcpv_out_if.sv
// fcpv_out_if: result channel of the page victim unit
// depends on fcpv_pkg
interface fcpv_out_if import fcpv_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             status;
	logic [FRAME_OUT_W-1:0] victim_frame;

	modport source (output valid, status, victim_frame, input ready);
	modport sink (input valid, status, victim_frame, output ready);
endinterface

>>> hdl/fcpv_cell.sv
// fcpv_cell: one table entry of the rotating page table
// holds used and resident flags plus page, count and frame; no package use
module fcpv_cell #(
	parameter int unsigned DATA_W = 46
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic [DATA_W-1:0] d,
	output logic [DATA_W-1:0] q
);
	logic [1:0]        flags_q;
	logic [DATA_W-3:0] data_q;

	// flags clear on reset, payload is undefined until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= 2'b00;
		end else if (shift) begin
			flags_q <= d[DATA_W-1:DATA_W-2];
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d[DATA_W-3:0];
		end
	end

	assign q = {flags_q, data_q};
endmodule

>>> hdl/future_count_page_victim_unit.sv
// future_count_page_victim_unit: top level, ring of entry cells and control sequencer
// depends on fcpv_pkg, fcpv_in_if, fcpv_out_if, fcpv_cell
//
// The page table is a ring of TABLE_ENTRIES cells that rotates by one place a
// cycle past a single head while a scan or write-back pass runs. Each request
// takes one full rotation to scan (lookup, first free entry, resident entry with
// smallest count), a decide step and a second full rotation to write the chosen
// entry back. A new request is taken while the previous result still waits on
// the output channel.
module future_count_page_victim_unit import fcpv_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = 256,
	parameter int unsigned PAGE_BITS     = 20,
	parameter int unsigned FRAME_BITS    = 8,
	parameter int unsigned COUNT_BITS    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [OFFSET_W-1:0] cfg_wdata,
	fcpv_in_if.sink             in_ch,
	fcpv_out_if.source          out_ch
);
	localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned EW = 2 + PAGE_BITS + COUNT_BITS + FRAME_BITS;
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
	localparam logic [COUNT_BITS-1:0] CNT_NEG1 = {COUNT_BITS{1'b1}};

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_APPLY, S_DONE} state_t;

	state_t                  state_q;
	logic [OFFSET_W-1:0]     offset_q;
	logic [IW-1:0]           k_q;
	action_t                 act_q;
	logic [PAGE_BITS-1:0]    pg_q;
	logic [FRAME_BITS-1:0]   fr_q;
	logic                    match_q, free_q, best_q, wr_q;
	logic [IW-1:0]           match_idx_q, free_idx_q, best_idx_q, tgt_q;
	logic [COUNT_BITS-1:0]   best_cnt_q;
	logic [FRAME_BITS-1:0]   best_fr_q;
	status_t                 st_q;
	logic [FRAME_OUT_W-1:0]  vf_q;
	logic                    out_valid_q;
	status_t                 out_st_q;
	logic [FRAME_OUT_W-1:0]  out_vf_q;

	logic [EW-1:0]           ring [TABLE_ENTRIES];
	logic [EW-1:0]           head, tail_d;
	logic                    shift;
	logic                    h_used, h_res;
	logic [PAGE_BITS-1:0]    h_page;
	logic [COUNT_BITS-1:0]   h_cnt, cnt_new;
	logic [FRAME_BITS-1:0]   h_fr;

	// ring of cells, each takes its upper neighbor; the last takes the head write-back
	assign shift = (state_q == S_SCAN) || (state_q == S_APPLY);
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		fcpv_cell #(.DATA_W(EW)) u_cell (
			.clk(clk), .arst_n(arst_n), .shift(shift),
			.d((i == TABLE_ENTRIES - 1) ? tail_d : ring[(i + 1) % TABLE_ENTRIES]),
			.q(ring[i])
		);
	end

	assign head = ring[0];
	assign {h_used, h_res, h_page, h_cnt, h_fr} = head;

	// head entry update during the write-back pass
	always_comb begin
		cnt_new = h_cnt;
		tail_d  = head;
		if (state_q == S_APPLY && wr_q && k_q == tgt_q) begin
			case (act_q)
				ACT_RECORD: begin
					if (match_q) begin
						cnt_new = (h_cnt == CNT_MAX) ? h_cnt : h_cnt + 1'b1;
						tail_d  = {h_used, h_res, h_page, cnt_new, h_fr};
					end else begin
						tail_d = {1'b1, 1'b0, pg_q, {COUNT_BITS{1'b0}}, h_fr};
					end
				end
				ACT_ACCESS: begin
					cnt_new = (h_cnt == CNT_MIN) ? h_cnt : h_cnt - 1'b1;
					tail_d  = {h_used, h_res, h_page, cnt_new, h_fr};
				end
				ACT_PLACE: tail_d = {h_used, 1'b1, h_page, h_cnt, fr_q};
				default:   tail_d = {(h_cnt != CNT_NEG1) & h_used, 1'b0, h_page, h_cnt, h_fr};
			endcase
		end
	end

	assign in_ch.ready         = (state_q == S_IDLE);
	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = out_st_q;
	assign out_ch.victim_frame = out_vf_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			act_q <= action_t'(in_ch.action);
			fr_q  <= FRAME_BITS'(in_ch.frame);
			if (action_t'(in_ch.action) == ACT_RECORD) begin
				pg_q <= PAGE_BITS'(in_ch.address >> offset_q);
			end else begin
				pg_q <= PAGE_BITS'(in_ch.page);
			end
		end
	end

	// scan results, decision and output result payload
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			if (h_used && h_page == pg_q && !match_q) begin
				match_idx_q <= k_q;
			end
			if (!h_used && !free_q) begin
				free_idx_q <= k_q;
			end
			if (h_used && h_res && (!best_q || $signed(h_cnt) < $signed(best_cnt_q))) begin
				best_idx_q <= k_q;
				best_cnt_q <= h_cnt;
				best_fr_q  <= h_fr;
			end
		end
		if (state_q == S_DECIDE) begin
			case (act_q) inside
				ACT_RECORD: begin
					tgt_q <= match_q ? match_idx_q : free_idx_q;
					st_q  <= (match_q || free_q) ? ST_OK : ST_FULL;
					vf_q  <= '0;
				end
				ACT_ACCESS, ACT_PLACE: begin
					tgt_q <= match_idx_q;
					st_q  <= match_q ? ST_OK : ST_NOT_FOUND;
					vf_q  <= '0;
				end
				default: begin
					tgt_q <= best_idx_q;
					st_q  <= best_q ? ST_OK : ST_NO_RESIDENT;
					vf_q  <= best_q ? FRAME_OUT_W'(best_fr_q) : '0;
				end
			endcase
		end
		if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
			out_st_q <= st_q;
			out_vf_q <= vf_q;
		end
	end

	// sequencer: scan pass, decide, write-back pass, hand result to output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			best_q      <= 1'b0;
			wr_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: load a finished result or drop a taken one
			if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						state_q <= S_SCAN;
						k_q     <= '0;
						match_q <= 1'b0;
						free_q  <= 1'b0;
						best_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (h_used && h_page == pg_q) match_q <= 1'b1;
					if (!h_used) free_q <= 1'b1;
					if (h_used && h_res) best_q <= 1'b1;
					if (k_q == LAST) begin
						k_q     <= '0;
						state_q <= S_DECIDE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DECIDE: begin
					unique case (act_q) inside
						ACT_RECORD:            wr_q <= match_q || free_q;
						ACT_ACCESS, ACT_PLACE: wr_q <= match_q;
						default:               wr_q <= best_q;
					endcase
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (k_q == LAST) begin
						k_q     <= '0;
						state_q <= S_DONE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a transfer in always starts a scan pass
	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> (state_q == S_SCAN && k_q == '0))
		else $error("scan did not start after request transfer");

	// the rotation index steps by one through each pass
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN || state_q == S_APPLY) && k_q != LAST) |=>
		(k_q == $past(k_q) + 1'b1))
		else $error("rotation index skipped");

	// a freed frame is only reported with ok status
	a_vf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q != ST_OK) |-> (out_vf_q == '0))
		else $error("victim frame nonzero on failing status");

	// the table never moves while a new request can be taken
	a_idle_still: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !shift)
		else $error("ring rotating while idle");
endmodule

>>> tb/sv/testbench.sv
// testbench: self-checking bench for future_count_page_victim_unit
// depends on fcpv_pkg, fcpv_in_if, fcpv_out_if and the unit itself
module testbench;
	import fcpv_pkg::*;

	localparam int ENTRIES = 256;
	localparam int CNT_W = 16;
	localparam int ITEM_CYCLES = 2 * ENTRIES + 2;

	typedef struct packed {
		action_t            action;
		logic [ADDR_W-1:0]  address;
		logic [19:0]        page;
		logic [7:0]         frame;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  victim_frame;
	} answer_t;

	logic clk, arst_n, cfg_we;
	logic [OFFSET_W-1:0] cfg_wdata;
	fcpv_in_if in_ch ();
	fcpv_out_if out_ch ();

	future_count_page_victim_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	// page table copy held by the bench
	logic                    tbl_used [ENTRIES];
	logic [19:0]             tbl_page [ENTRIES];
	logic signed [CNT_W-1:0] tbl_count [ENTRIES];
	logic                    tbl_res [ENTRIES];
	logic [7:0]              tbl_frame [ENTRIES];
	logic [OFFSET_W-1:0]     shift_amt;

	request_t pending_reqs[$];
	answer_t  expected_answers[$];
	int  fail_count = 0;
	int  send_idle_pct = 0, recv_stall_pct = 0;
	int  hold_off_cycles = 0;
	logic [19:0] known_pages[$];
	logic in_taken = 1'b0;

	// clock
	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	function automatic int lookup_page(logic [19:0] pg);
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_used[i] && tbl_page[i] == pg) return i;
		return -1;
	endfunction

	// compute the answer of one request and update the table copy
	function automatic answer_t predict_answer(request_t r);
		answer_t a;
		int idx, best;
		logic [19:0] pg;
		a.status = ST_OK;
		a.victim_frame = '0;
		case (r.action)
			ACT_RECORD: begin
				pg = 20'(r.address >> shift_amt);
				idx = lookup_page(pg);
				if (idx >= 0) begin
					if (tbl_count[idx] != 16'sh7fff) tbl_count[idx] = tbl_count[idx] + 1;
				end else begin
					idx = -1;
					for (int i = 0; i < ENTRIES; i++)
						if (!tbl_used[i] && idx < 0) idx = i;
					if (idx < 0) a.status = ST_FULL;
					else begin
						tbl_used[idx] = 1'b1;
						tbl_page[idx] = pg;
						tbl_count[idx] = '0;
						tbl_res[idx] = 1'b0;
						tbl_frame[idx] = '0;
					end
				end
			end
			ACT_ACCESS: begin
				idx = lookup_page(r.page);
				if (idx < 0) a.status = ST_NOT_FOUND;
				else if (tbl_count[idx] != 16'sh8000) tbl_count[idx] = tbl_count[idx] - 1;
			end
			ACT_PLACE: begin
				idx = lookup_page(r.page);
				if (idx < 0) a.status = ST_NOT_FOUND;
				else begin
					tbl_frame[idx] = r.frame;
					tbl_res[idx] = 1'b1;
				end
			end
			default: begin
				best = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (tbl_used[i] && tbl_res[i] && (best < 0 || tbl_count[i] < tbl_count[best]))
						best = i;
				if (best < 0) a.status = ST_NO_RESIDENT;
				else begin
					a.victim_frame = tbl_frame[best];
					tbl_res[best] = 1'b0;
					if (tbl_count[best] == -16'sd1) tbl_used[best] = 1'b0;
				end
			end
		endcase
		return a;
	endfunction

	// driver: offer the head of the queue at the falling edge, hold it until taken
	always @(negedge clk) begin
		logic go;
		go = pending_reqs.size() > 0 && arst_n &&
			($urandom_range(99) >= send_idle_pct || in_ch.valid && !in_taken);
		if (go) begin
			request_t r;
			r = pending_reqs[0];
			in_ch.action <= r.action;
			in_ch.address <= r.address;
			in_ch.page <= r.page;
			in_ch.frame <= r.frame;
		end
		in_ch.valid <= go;
	end

	// receiver stall control
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ch.ready <= 1'b0;
		end else
			out_ch.ready <= $urandom_range(99) >= recv_stall_pct;
	end

	// input monitor: retire the driven request and predict on each accepted transfer
	always @(posedge clk) begin
		in_taken <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			void'(pending_reqs.pop_front());
			expected_answers.push_back(predict_answer(request_t'{
				action_t'(in_ch.action), in_ch.address, in_ch.page, in_ch.frame}));
		end
	end

	// output monitor: compare each result transfer
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_answers.size() == 0) begin
				$error("result with no request pending: status %0d", out_ch.status);
				fail_count++;
			end else begin
				answer_t e;
				e = expected_answers.pop_front();
				if (out_ch.status !== e.status) begin
					$error("status expected %0d got %0d", e.status, out_ch.status);
					fail_count++;
				end
				if (out_ch.victim_frame !== e.victim_frame) begin
					$error("victim_frame expected %0d got %0d", e.victim_frame,
						out_ch.victim_frame);
					fail_count++;
				end
			end
		end
	end

	function automatic request_t make_req(action_t a, logic [31:0] ad, logic [19:0] pg,
		logic [7:0] fr);
		request_t r;
		r.action = a; r.address = ad; r.page = pg; r.frame = fr;
		return r;
	endfunction

	// record an address and remember its page for later well-formed requests
	task automatic queue_record(logic [31:0] ad);
		pending_reqs.push_back(make_req(ACT_RECORD, ad, '0, '0));
		known_pages.push_back(20'(ad >> shift_amt));
	endtask

	function automatic logic [19:0] pick_page();
		if (known_pages.size() == 0 || $urandom_range(9) == 0) return 20'($urandom);
		return known_pages[$urandom_range(known_pages.size() - 1)];
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || expected_answers.size() > 0) @(posedge clk);
		repeat (ITEM_CYCLES + 10) @(posedge clk);
	endtask

	task automatic write_shift(logic [OFFSET_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		shift_amt = v;
	endtask

	task automatic queue_random(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 30) begin
				if ($urandom_range(3) == 0 && known_pages.size() > 0)
					queue_record(32'(known_pages[$urandom_range(known_pages.size() - 1)])
						<< shift_amt);
				else queue_record($urandom);
			end else if (k < 55)
				pending_reqs.push_back(make_req(ACT_ACCESS, $urandom, pick_page(),
					8'($urandom)));
			else if (k < 80)
				pending_reqs.push_back(make_req(ACT_PLACE, $urandom, pick_page(),
					8'($urandom)));
			else
				pending_reqs.push_back(make_req(ACT_VICTIM, $urandom, 20'($urandom),
					8'($urandom)));
		end
	endtask

	// stimulus
	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_used[i] = 0; tbl_res[i] = 0; tbl_page[i] = 0;
			tbl_count[i] = 0; tbl_frame[i] = 0;
		end
		shift_amt = OFFSET_RESET;
		arst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
		in_ch.valid = 1'b0; in_ch.action = ACT_RECORD; in_ch.address = '0;
		in_ch.page = '0; in_ch.frame = '0; out_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: empty table, extreme pages and frames
		pending_reqs.push_back(make_req(ACT_VICTIM, '0, '0, '0));
		pending_reqs.push_back(make_req(ACT_ACCESS, '0, 20'hfffff, '0));
		pending_reqs.push_back(make_req(ACT_PLACE, '0, 20'h12345, 8'hff));
		queue_record(32'hffffffff);
		queue_record(32'h0);
		queue_record(32'h00000fff);
		pending_reqs.push_back(make_req(ACT_PLACE, '0, 20'hfffff, 8'hff));
		pending_reqs.push_back(make_req(ACT_PLACE, '0, 20'h0, 8'h00));
		pending_reqs.push_back(make_req(ACT_PLACE, '0, 20'h0, 8'h5a));
		pending_reqs.push_back(make_req(ACT_ACCESS, '0, 20'h0, '0));
		pending_reqs.push_back(make_req(ACT_VICTIM, '0, '0, '0));
		pending_reqs.push_back(make_req(ACT_VICTIM, '0, '0, '0));
		pending_reqs.push_back(make_req(ACT_VICTIM, '0, '0, '0));
		wait_drained();
		write_shift(5'd0);
		queue_record(32'h000fffff);
		queue_record(32'hfff00000);
		wait_drained();
		write_shift(5'd31);
		queue_record(32'h80000000);
		queue_random(4);
		wait_drained();

		// fill the table to reach table full at a small shift
		write_shift(5'd1);
		for (int i = 0; i < 270; i++) queue_record(32'(i) << 1);
		queue_random(30);
		// long receiver hold-off while requests keep coming
		@(negedge clk) hold_off_cycles = 3 * ITEM_CYCLES;
		wait_drained();

		// random phases with different idling and shift settings
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? 57 : 0;
			recv_stall_pct = (ph == 2) ? 57 : (ph == 3 ? 19 : 0);
			if (ph == 3) send_idle_pct = 19;
			write_shift(ph == 0 ? 5'd31 : 5'($urandom_range(31)));
			known_pages.delete();
			queue_random(160);
			wait_drained();
		end

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// timeout
	initial begin
		#(12 * 6000 * ITEM_CYCLES);
		$display("Test completed with failures");
		$finish;
	end
endmodule

>>> sim.f
hdl/fcpv_pkg.sv
hdl/fcpv_in_if.sv
hdl/fcpv_out_if.sv
hdl/fcpv_cell.sv
hdl/future_count_page_victim_unit.sv
tb/sv/testbench.sv
